### src/sgm_pkg.sv
// Shared types and constants for the Sobel gradient magnitude block.
package sgm_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 16;
    localparam int CFG_W      = 16;
    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 11;
    localparam int SQ_W       = 20;
    localparam int ENERGY_W   = 21;

    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_GRAD,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic grad;
        logic square;
        logic sum;
        logic root_step;
        logic emit;
    } sgm_cmd_t;

    typedef struct packed {
        logic has_result;
        logic root_last;
        logic out_free;
        logic more;
    } sgm_status_t;

endpackage

### src/sgm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

### src/sgm_ctrl.sv
// Controller state machine sequencing accept, load, gradient, square, sum, root and emit steps.
module sgm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  sgm_pkg::sgm_status_t st,
    output sgm_pkg::sgm_cmd_t    cmd
);
    import sgm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = st.has_result ? ST_GRAD : ST_IDLE;
            end
            ST_GRAD: begin
                cmd.grad   = 1'b1;
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (st.root_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = st.more ? ST_GRAD : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

### src/sgm_datapath.sv
// Datapath: counters, line stores, window, Sobel sums, square root, output register.
module sgm_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_addr,
    input  logic [sgm_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic [7:0]                        s_tdata,
    input  sgm_pkg::sgm_cmd_t                 cmd,
    output sgm_pkg::sgm_status_t              st,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);
    import sgm_pkg::*;

    logic [11:0]        width_reg;
    logic [15:0]        height_reg;
    logic [COL_W-1:0]   wlast;
    logic [ROW_W-1:0]   hlast;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   cur_c_reg;
    logic [ROW_W-1:0]   cur_r_reg;
    logic [PIX_W-1:0]   px_reg;
    logic [PIX_W-1:0]   above, above2;
    logic [PIX_W-1:0]   win_reg [3][3];
    logic               lastc_reg, lastr_reg, r1_reg, c1_reg;
    logic [1:0]         sel_reg;
    logic [1:0]         sel_next;
    logic               more;
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic signed [2*GRAD_W-1:0] sqx_full, sqy_full;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg;
    logic [ENERGY_W-1:0] e_reg;
    logic [7:0]         root_reg;
    logic [2:0]         bit_reg;
    logic [7:0]         trial;
    logic [15:0]        trial_sq;
    logic               mvalid_reg;
    logic [39:0]        mdata_reg;
    logic               mlast_reg, muser_reg;
    logic [1:0]         wi [3];
    logic [1:0]         wj [3];
    logic [PIX_W-1:0]   p [3][3];
    logic [GRAD_W-1:0]  pos_x, neg_x, pos_y, neg_y;
    logic [ROW_W-1:0]   rr;
    logic [COL_W-1:0]   cc;
    logic [7:0]         mag;

    always_comb begin
        if (width_reg < 12'd3) begin
            wlast = COL_W'(2);
        end else if (width_reg > 12'(MAX_WIDTH)) begin
            wlast = COL_W'(MAX_WIDTH - 1);
        end else begin
            wlast = COL_W'(width_reg - 12'd1);
        end
        hlast = (height_reg < 16'd3) ? 16'd2 : height_reg - 16'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_IMAGE_WIDTH) begin
                width_reg <= cfg_wr_data[11:0];
            end else begin
                height_reg <= cfg_wr_data;
            end
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.accept) begin
            if (col_reg >= wlast) begin
                col_reg <= '0;
                row_reg <= (row_reg >= hlast) ? '0 : row_reg + 16'd1;
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line1 (
        .aclk  (aclk),
        .we    (cmd.load),
        .waddr (cur_c_reg),
        .wdata (px_reg),
        .re    (cmd.accept),
        .raddr (col_reg),
        .rdata (above)
    );

    sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line2 (
        .aclk  (aclk),
        .we    (cmd.load),
        .waddr (cur_c_reg),
        .wdata (above),
        .re    (cmd.accept),
        .raddr (col_reg),
        .rdata (above2)
    );

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            px_reg    <= s_tdata;
            cur_c_reg <= col_reg;
            cur_r_reg <= row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= above2;
            win_reg[1][2] <= above;
            win_reg[2][2] <= px_reg;
        end
    end

    assign st.has_result = (cur_r_reg != '0) && (cur_c_reg != '0);

    always_comb begin
        sel_next = sel_reg;
        more     = 1'b0;
        case (sel_reg)
            2'b00: begin
                if (lastc_reg) begin
                    sel_next = 2'b01;
                    more     = 1'b1;
                end else if (lastr_reg) begin
                    sel_next = 2'b10;
                    more     = 1'b1;
                end
            end
            2'b01: begin
                if (lastr_reg) begin
                    sel_next = 2'b10;
                    more     = 1'b1;
                end
            end
            2'b10: begin
                if (lastc_reg) begin
                    sel_next = 2'b11;
                    more     = 1'b1;
                end
            end
            default: begin
                more = 1'b0;
            end
        endcase
    end

    assign st.more = more;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lastc_reg <= (cur_c_reg == wlast);
            lastr_reg <= (cur_r_reg == hlast);
            r1_reg    <= (cur_r_reg == 16'd1);
            c1_reg    <= (cur_c_reg == COL_W'(1));
            sel_reg   <= 2'b00;
        end else if (cmd.emit) begin
            sel_reg <= sel_next;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            wi[k] = sel_reg[1] + 2'(k);
            wj[k] = sel_reg[0] + 2'(k);
            if (k == 0 && !sel_reg[1] && r1_reg) begin
                wi[k] = 2'd1;
            end
            if (k == 2 && sel_reg[1]) begin
                wi[k] = 2'd2;
            end
            if (k == 0 && !sel_reg[0] && c1_reg) begin
                wj[k] = 2'd1;
            end
            if (k == 2 && sel_reg[0]) begin
                wj[k] = 2'd2;
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                p[i][j] = win_reg[wi[i]][wj[j]];
            end
        end
        pos_x = GRAD_W'(p[0][0]) + GRAD_W'({p[1][0], 1'b0}) + GRAD_W'(p[2][0]);
        neg_x = GRAD_W'(p[0][2]) + GRAD_W'({p[1][2], 1'b0}) + GRAD_W'(p[2][2]);
        pos_y = GRAD_W'(p[2][0]) + GRAD_W'({p[2][1], 1'b0}) + GRAD_W'(p[2][2]);
        neg_y = GRAD_W'(p[0][0]) + GRAD_W'({p[0][1], 1'b0}) + GRAD_W'(p[0][2]);
    end

    assign sqx_full = gx_reg * gx_reg;
    assign sqy_full = gy_reg * gy_reg;

    always_ff @(posedge aclk) begin
        if (cmd.grad) begin
            gx_reg <= $signed(pos_x - neg_x);
            gy_reg <= $signed(pos_y - neg_y);
        end
        if (cmd.square) begin
            sqx_reg <= sqx_full[SQ_W-1:0];
            sqy_reg <= sqy_full[SQ_W-1:0];
        end
        if (cmd.sum) begin
            e_reg <= ENERGY_W'(sqx_reg) + ENERGY_W'(sqy_reg);
        end
    end

    assign trial    = root_reg | (8'd1 << bit_reg);
    assign trial_sq = 16'(trial) * 16'(trial);

    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            root_reg <= '0;
            bit_reg  <= 3'd7;
        end else if (cmd.root_step) begin
            if (trial_sq <= e_reg[15:0]) begin
                root_reg <= trial;
            end
            bit_reg <= bit_reg - 3'd1;
        end
    end

    assign st.root_last = (bit_reg == 3'd0);
    assign st.out_free  = !mvalid_reg || m_tready;

    assign rr  = cur_r_reg - 16'd1 + 16'(sel_reg[1]);
    assign cc  = cur_c_reg - COL_W'(1) + COL_W'(sel_reg[0]);
    assign mag = (e_reg[ENERGY_W-1:16] != '0) ? 8'hFF : root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            mdata_reg <= {5'd0, mag, cc, rr};
            mlast_reg <= !more;
            muser_reg <= (rr == hlast) && (cc == wlast);
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;
    assign m_tuser  = muser_reg;
endmodule

### src/sobel_gradient_magnitude_top.sv
// Each accepted pixel is registered and loaded into the window and line stores; each of its
// results (up to four) then passes grad, square, sum, root and emit into the output register.
// A new pixel is taken only after the last result of the previous one is emitted; the shared
// 8-step square root loop serves each result, and emit waits while the output is stalled.
// Reset: synchronous active-low aresetn clears counters, window and control and
// restores width 640 and height 480; line store contents are kept.
module sobel_gradient_magnitude_top (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_addr,
    input  logic [sgm_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // pixel[7:0]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [39:0]               m_tdata,   // out_row[15:0], out_col[26:16], magnitude[34:27]
    output logic                      m_tlast,
    output logic                      m_tuser    // frame_done
);
    import sgm_pkg::*;

    sgm_cmd_t    cmd;
    sgm_status_t st;

    sgm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sgm_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .st          (st),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

`ifndef SYNTHESIS
    a_frame_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast) else $error("frame_done without tlast");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("ready while loading");
    a_busy_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready) else $error("ready inside a run");
`endif
endmodule

### tb/sobel_gradient_magnitude_top_tb.sv
// Self-checking testbench for the streaming Sobel gradient magnitude block.
module sobel_gradient_magnitude_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sgm_pkg::*;

    typedef struct {
        logic [15:0] row;
        logic [10:0] col;
        logic [7:0]  mag;
        logic        last;
        logic        frame_done;
    } edge_result_t;

    class edge_scoreboard;
        logic [7:0]  above_line [0:MAX_WIDTH-1];
        logic [7:0]  above2_line [0:MAX_WIDTH-1];
        logic [7:0]  win [0:2][0:2];
        int unsigned row_pos, col_pos;
        int unsigned width_reg, height_reg;
        edge_result_t pending [$];
        int errors;
        int results_seen;

        function new();
            foreach (win[i, j]) win[i][j] = 8'd0;
            row_pos = 0;
            col_pos = 0;
            width_reg = 640;
            height_reg = 480;
            errors = 0;
            results_seen = 0;
        endfunction

        function void write_reg(cfg_index_t idx, int unsigned val);
            if (idx == REG_IMAGE_WIDTH) width_reg = val & 12'hFFF;
            else height_reg = val & 16'hFFFF;
            row_pos = 0;
            col_pos = 0;
        endfunction

        function int eff_w();
            int w;
            w = width_reg;
            if (w < 3) w = 3;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            return w;
        endfunction

        function int eff_h();
            return (height_reg < 3) ? 3 : height_reg;
        endfunction

        function int clip(int v, int lo, int hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function logic [7:0] sobel_mag(int rr, int cc, int r, int c, int w, int h);
            int gx, gy, tr, tc, wi, wj, p, e, s;
            gx = 0;
            gy = 0;
            for (int i = 0; i < 3; i++) begin
                tr = clip(rr + i - 1, 0, h - 1);
                wi = clip(2 - (r - tr), 0, 2);
                for (int j = 0; j < 3; j++) begin
                    tc = clip(cc + j - 1, 0, w - 1);
                    wj = clip(2 - (c - tc), 0, 2);
                    p = win[wi][wj];
                    gy += p * (i == 0 ? -1 : (i == 2 ? 1 : 0)) * (j == 1 ? 2 : 1);
                    gx += p * (j == 0 ? 1 : (j == 2 ? -1 : 0)) * (i == 1 ? 2 : 1);
                end
            end
            e = gx * gx + gy * gy;
            if (e >= 65536) return 8'd255;
            s = 0;
            while ((s + 1) * (s + 1) <= e) s++;
            return s[7:0];
        endfunction

        function void note_pixel(logic [7:0] px);
            int w, h, r, c, n;
            int pr [4];
            int pc [4];
            logic [7:0] a1, a2;
            edge_result_t res;
            w = eff_w();
            h = eff_h();
            r = row_pos;
            c = col_pos;
            n = 0;
            a1 = above_line[c];
            a2 = above2_line[c];
            above2_line[c] = a1;
            above_line[c] = px;
            for (int i = 0; i < 3; i++) begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
            end
            win[0][2] = a2;
            win[1][2] = a1;
            win[2][2] = px;
            if (r >= 1 && c >= 1) begin
                pr[n] = r - 1; pc[n] = c - 1; n++;
                if (c == w - 1) begin
                    pr[n] = r - 1; pc[n] = c; n++;
                end
                if (r == h - 1) begin
                    pr[n] = r; pc[n] = c - 1; n++;
                    if (c == w - 1) begin
                        pr[n] = r; pc[n] = c; n++;
                    end
                end
            end
            for (int k = 0; k < n; k++) begin
                res.row = 16'(pr[k]);
                res.col = 11'(pc[k]);
                res.mag = sobel_mag(pr[k], pc[k], r, c, w, h);
                res.last = (k == n - 1);
                res.frame_done = (pr[k] == h - 1 && pc[k] == w - 1);
                pending.push_back(res);
            end
            if (c >= w - 1) begin
                col_pos = 0;
                row_pos = (r >= h - 1) ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
            end
        endfunction

        function void report_mismatch(string msg);
            errors++;
            $display("MISMATCH %0t: %s", $time, msg);
        endfunction

        function void check_result(logic [39:0] data, logic last, logic fdone);
            edge_result_t want;
            results_seen++;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result data=%h", data));
                return;
            end
            want = pending.pop_front();
            if (data[15:0] !== want.row || data[26:16] !== want.col ||
                data[34:27] !== want.mag || last !== want.last ||
                fdone !== want.frame_done)
                report_mismatch($sformatf(
                    "got r%0d c%0d m%0d l%b f%b, want r%0d c%0d m%0d l%b f%b",
                    data[15:0], data[26:16], data[34:27], last, fdone,
                    want.row, want.col, want.mag, want.last, want.frame_done));
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_addr = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic m_tlast;
    logic m_tuser;

    edge_scoreboard sb = new();
    int hold_off_cycles = 0;
    int pixels_sent = 0;

    always #4 aclk = ~aclk;

    sobel_gradient_magnitude_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(negedge aclk);
                hold_off_cycles = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (gap > 0 && $urandom_range(0, 1)) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_pixel(logic [7:0] px, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= px;
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(px);
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, int unsigned val);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= CFG_W'(val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic send_frame_part(int count, int mode, bit busy);
        logic [7:0] px;
        int gap;
        for (int i = 0; i < count; i++) begin
            case (mode)
                0: px = 8'($urandom_range(0, 255));
                1: px = (i % 2) ? 8'hFF : 8'h00;
                default: px = ($urandom_range(0, 1)) ? 8'hFF : 8'($urandom_range(0, 255));
            endcase
            gap = busy ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16));
            send_pixel(px, gap);
        end
    endtask

    initial begin
        int w, h;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: minimal frame with extremes, then out-of-range sizes
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 3);
        send_frame_part(9, 1, 1'b0);
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 1);
        for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 8'hFF : 8'h00, 0);
        write_reg(REG_IMAGE_WIDTH, 4);
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        send_frame_part(4, 0, 1'b0);

        // random frames: small sizes, the first sent back to back, then the clamped maximum width
        write_reg(REG_IMAGE_WIDTH, 5);
        write_reg(REG_IMAGE_HEIGHT, 4);
        hold_off_cycles = 300;
        send_frame_part(45, 2, 1'b1);
        drain_results();
        w = $urandom_range(3, 8);
        h = $urandom_range(3, 6);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        send_frame_part(w * h * 2, 0, 1'b0);
        write_reg(REG_IMAGE_WIDTH, 12'hFFF);
        write_reg(REG_IMAGE_HEIGHT, 3);
        send_frame_part(40, 0, 1'b0);
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, $urandom_range(3, 10));
        send_frame_part(60, 2, 1'b0);
        drain_results();
        $display("covered %0d pixels, %0d results, sizes 3x3 to max width, clamped sizes",
                 pixels_sent, sb.results_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("sobel_gradient_magnitude_top_tb: done, clean");
        else
            $display("sobel_gradient_magnitude_top_tb: done, errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("sobel_gradient_magnitude_top_tb: done, errors");
        $finish;
    end
endmodule
